// ----- rtl/yqr_pkg.sv -----
// Shared constants, types and register codes for the YUV 4:2:0 quad to RGB converter.
package yqr_pkg;

    localparam int SAMPLE_W   = 8;
    localparam int CHROMA_W   = SAMPLE_W + 1;
    localparam int TERM_W     = 30;
    localparam int SUM_W      = 32;
    localparam int FRAC_BITS  = 20;
    localparam int QUAD_SIZE  = 4;
    localparam int POS_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int QUEUE_DEPTH = 2;

    localparam logic signed [SUM_W-1:0] COEF_Y  = 32'sd1220542;
    localparam logic signed [SUM_W-1:0] COEF_UB = 32'sd2116026;
    localparam logic signed [SUM_W-1:0] COEF_UG = -32'sd409993;
    localparam logic signed [SUM_W-1:0] COEF_VG = -32'sd852492;
    localparam logic signed [SUM_W-1:0] COEF_VR = 32'sd1673527;
    localparam logic signed [SUM_W-1:0] ROUND_HALF = 32'sd524288;

    localparam logic [SAMPLE_W-1:0] LUMA_OFS   = 8'd16;
    localparam logic signed [CHROMA_W-1:0] CHROMA_OFS = 9'sd128;
    localparam logic [SAMPLE_W-1:0] ALPHA_ON   = 8'hff;
    localparam logic [SAMPLE_W-1:0] ALPHA_OFF  = 8'h00;
    localparam logic [SAMPLE_W-1:0] CHAN_MAX   = 8'hff;
    localparam logic [POS_W-1:0]    POS_LAST   = 2'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BLUE_FIRST   = 2'd0,
        CFG_CHROMA_ORDER = 2'd1,
        CFG_FOUR_CHANNEL = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic blue_first;
        logic chroma_order;
        logic four_channel;
    } cfg_t;

    // One quad after chroma classification: raw luma and the three chroma terms.
    typedef struct packed {
        logic [QUAD_SIZE-1:0][SAMPLE_W-1:0] luma;
        logic signed [TERM_W-1:0]            ruv;
        logic signed [TERM_W-1:0]            guv;
        logic signed [TERM_W-1:0]            buv;
    } quad_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] channel0;
        logic [SAMPLE_W-1:0] channel1;
        logic [SAMPLE_W-1:0] channel2;
        logic [SAMPLE_W-1:0] alpha;
        logic [POS_W-1:0]    pixel_pos;
        logic                last;
    } pixel_t;

endpackage

// ----- rtl/yuv420_quad_to_rgb_unit.sv -----
// Top level of the YUV 4:2:0 quad to RGB converter with its configuration registers.
//
// Input side is a queue: present a 2x2 luma quad and its chroma pair and raise push;
// the quad is taken at a clock edge where push is high and full is low.
// Output side is a queue too: while empty is low the oldest pixel sits on channel0..2,
// alpha, pixel_pos and last, and it is taken at an edge where pop is high.
// Each quad yields four pixels in raster order; last marks the bottom-right one.
// Throughput is one pixel per cycle while pop is high and a quad is queued; the
// back end's single multiply-add-clip datapath, reused for the four luma samples,
// sets that rate. A quad passes the front register, the quad queue and the pixel
// register before its first pixel appears on the outputs.
// When the receiver holds off pop, the pixel register holds, the back end stops, the
// quad queue fills, and full rises once the front register also holds a quad.
// Configuration writes use cfg_valid/cfg_ready (always ready); cfg_index selects the
// register and bit 0 of cfg_data is stored. Unknown indexes are ignored.
// Reset empties all stages and sets blue_first=1, chroma_order=0, four_channel=0.
module yuv420_quad_to_rgb_unit
#(
    parameter int QUEUE_DEPTH = yqr_pkg::QUEUE_DEPTH
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [yqr_pkg::SAMPLE_W-1:0]      luma_top_left,
    input  logic [yqr_pkg::SAMPLE_W-1:0]      luma_top_right,
    input  logic [yqr_pkg::SAMPLE_W-1:0]      luma_bottom_left,
    input  logic [yqr_pkg::SAMPLE_W-1:0]      luma_bottom_right,
    input  logic [yqr_pkg::SAMPLE_W-1:0]      chroma_first,
    input  logic [yqr_pkg::SAMPLE_W-1:0]      chroma_second,
    output logic                              empty,
    input  logic                              pop,
    output logic [yqr_pkg::SAMPLE_W-1:0]      channel0,
    output logic [yqr_pkg::SAMPLE_W-1:0]      channel1,
    output logic [yqr_pkg::SAMPLE_W-1:0]      channel2,
    output logic [yqr_pkg::SAMPLE_W-1:0]      alpha,
    output logic [yqr_pkg::POS_W-1:0]         pixel_pos,
    output logic                              last,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [yqr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [yqr_pkg::CFG_DATA_W-1:0]    cfg_data
);

    yqr_pkg::cfg_t                                          cfg_reg;
    yqr_pkg::cfg_t                                          cfg_next;
    logic [yqr_pkg::QUAD_SIZE-1:0][yqr_pkg::SAMPLE_W-1:0]   luma;
    logic                                                   q_push;
    yqr_pkg::quad_t                                         q_wr_data;
    logic                                                   q_full;
    logic                                                   q_pop;
    yqr_pkg::quad_t                                         q_rd_data;
    logic                                                   q_empty;
    yqr_pkg::pixel_t                                        pixel;

    assign cfg_ready = 1'b1;

    assign luma[0] = luma_top_left;
    assign luma[1] = luma_top_right;
    assign luma[2] = luma_bottom_left;
    assign luma[3] = luma_bottom_right;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                yqr_pkg::CFG_BLUE_FIRST:   cfg_next.blue_first   = cfg_data[0];
                yqr_pkg::CFG_CHROMA_ORDER: cfg_next.chroma_order = cfg_data[0];
                yqr_pkg::CFG_FOUR_CHANNEL: cfg_next.four_channel = cfg_data[0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.blue_first   <= 1'b1;
            cfg_reg.chroma_order <= 1'b0;
            cfg_reg.four_channel <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    yqr_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .luma          (luma),
        .chroma_first  (chroma_first),
        .chroma_second (chroma_second),
        .cfg           (cfg_reg),
        .q_push        (q_push),
        .q_data        (q_wr_data),
        .q_full        (q_full)
    );

    yqr_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wr_data),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .rd_data (q_rd_data),
        .q_empty (q_empty)
    );

    yqr_back u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_data  (q_rd_data),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .cfg     (cfg_reg),
        .pixel   (pixel),
        .empty   (empty),
        .pop     (pop)
    );

    assign channel0  = pixel.channel0;
    assign channel1  = pixel.channel1;
    assign channel2  = pixel.channel2;
    assign alpha     = pixel.alpha;
    assign pixel_pos = pixel.pixel_pos;
    assign last      = pixel.last;

endmodule

// ----- rtl/yqr_front.sv -----
// Front end: accepts a quad, sorts the chroma pair into U and V and forms the chroma terms.
module yqr_front
(
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          push,
    output logic                                          full,
    input  logic [yqr_pkg::QUAD_SIZE-1:0][yqr_pkg::SAMPLE_W-1:0] luma,
    input  logic [yqr_pkg::SAMPLE_W-1:0]                  chroma_first,
    input  logic [yqr_pkg::SAMPLE_W-1:0]                  chroma_second,
    input  yqr_pkg::cfg_t                                 cfg,
    output logic                                          q_push,
    output yqr_pkg::quad_t                                q_data,
    input  logic                                          q_full
);

    logic                                                    valid_reg;
    logic                                                    valid_next;
    logic [yqr_pkg::QUAD_SIZE-1:0][yqr_pkg::SAMPLE_W-1:0]    luma_reg;
    logic signed [yqr_pkg::CHROMA_W-1:0]                     cu_reg;
    logic signed [yqr_pkg::CHROMA_W-1:0]                     cv_reg;
    logic signed [yqr_pkg::CHROMA_W-1:0]                     cu_next;
    logic signed [yqr_pkg::CHROMA_W-1:0]                     cv_next;
    logic [yqr_pkg::SAMPLE_W-1:0]                            u_raw;
    logic [yqr_pkg::SAMPLE_W-1:0]                            v_raw;
    logic signed [yqr_pkg::SUM_W-1:0]                        cu_ext;
    logic signed [yqr_pkg::SUM_W-1:0]                        cv_ext;
    logic signed [yqr_pkg::SUM_W-1:0]                        ruv_full;
    logic signed [yqr_pkg::SUM_W-1:0]                        guv_full;
    logic signed [yqr_pkg::SUM_W-1:0]                        buv_full;
    logic                                                    accept;

    assign full   = valid_reg && q_full;
    assign accept = push && !full;
    assign q_push = valid_reg && !q_full;

    always_comb
    begin
        u_raw   = cfg.chroma_order ? chroma_second : chroma_first;
        v_raw   = cfg.chroma_order ? chroma_first : chroma_second;
        cu_next = $signed({1'b0, u_raw}) - yqr_pkg::CHROMA_OFS;
        cv_next = $signed({1'b0, v_raw}) - yqr_pkg::CHROMA_OFS;
    end

    always_comb
    begin
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (q_push)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            luma_reg <= luma;
            cu_reg   <= cu_next;
            cv_reg   <= cv_next;
        end
    end

    // Chroma terms carry the rounding half so the back end needs only one add per channel.
    always_comb
    begin
        cu_ext   = {{(yqr_pkg::SUM_W - yqr_pkg::CHROMA_W){cu_reg[yqr_pkg::CHROMA_W-1]}}, cu_reg};
        cv_ext   = {{(yqr_pkg::SUM_W - yqr_pkg::CHROMA_W){cv_reg[yqr_pkg::CHROMA_W-1]}}, cv_reg};
        ruv_full = yqr_pkg::ROUND_HALF + cv_ext * yqr_pkg::COEF_VR;
        guv_full = yqr_pkg::ROUND_HALF + cv_ext * yqr_pkg::COEF_VG + cu_ext * yqr_pkg::COEF_UG;
        buv_full = yqr_pkg::ROUND_HALF + cu_ext * yqr_pkg::COEF_UB;
        q_data.luma = luma_reg;
        q_data.ruv  = ruv_full[yqr_pkg::TERM_W-1:0];
        q_data.guv  = guv_full[yqr_pkg::TERM_W-1:0];
        q_data.buv  = buv_full[yqr_pkg::TERM_W-1:0];
    end

endmodule

// ----- rtl/yqr_queue.sv -----
// Short queue of classified quads between the front and back ends.
module yqr_queue
#(
    parameter int DEPTH = yqr_pkg::QUEUE_DEPTH
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  yqr_pkg::quad_t wr_data,
    output logic           q_full,
    input  logic           rd_en,
    output yqr_pkg::quad_t rd_data,
    output logic           q_empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    yqr_pkg::quad_t   mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_wr;
    logic             do_rd;

    assign q_full  = (count_reg == CNT_W'(DEPTH));
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ----- rtl/yqr_back.sv -----
// Back end: walks the head quad's four luma samples, a pixel per cycle unless stalled.
module yqr_back
(
    input  logic           clk,
    input  logic           rst_n,
    input  yqr_pkg::quad_t q_data,
    input  logic           q_empty,
    output logic           q_pop,
    input  yqr_pkg::cfg_t  cfg,
    output yqr_pkg::pixel_t pixel,
    output logic           empty,
    input  logic           pop
);

    logic                               out_valid_reg;
    logic                               out_valid_next;
    yqr_pkg::pixel_t                    pixel_reg;
    yqr_pkg::pixel_t                    pixel_next;
    logic [yqr_pkg::POS_W-1:0]          pos_reg;
    logic                               advance;
    logic [yqr_pkg::SAMPLE_W-1:0]       y_raw;
    logic [yqr_pkg::SAMPLE_W-1:0]       y_off;
    logic signed [yqr_pkg::SUM_W-1:0]   y_ext;
    logic signed [yqr_pkg::SUM_W-1:0]   y_term;
    logic signed [yqr_pkg::SUM_W-1:0]   r_sum;
    logic signed [yqr_pkg::SUM_W-1:0]   g_sum;
    logic signed [yqr_pkg::SUM_W-1:0]   b_sum;
    logic [yqr_pkg::SAMPLE_W-1:0]       r_val;
    logic [yqr_pkg::SAMPLE_W-1:0]       g_val;
    logic [yqr_pkg::SAMPLE_W-1:0]       b_val;

    function automatic logic [yqr_pkg::SAMPLE_W-1:0] clip_shift(
        input logic signed [yqr_pkg::SUM_W-1:0] sum
    );
        logic [yqr_pkg::SAMPLE_W-1:0] res;
        if (sum[yqr_pkg::SUM_W-1])
        begin
            res = '0;
        end
        else if (sum[yqr_pkg::SUM_W-2:yqr_pkg::FRAC_BITS + yqr_pkg::SAMPLE_W] != '0)
        begin
            res = yqr_pkg::CHAN_MAX;
        end
        else
        begin
            res = sum[yqr_pkg::FRAC_BITS + yqr_pkg::SAMPLE_W - 1:yqr_pkg::FRAC_BITS];
        end
        return res;
    endfunction

    assign empty   = !out_valid_reg;
    assign pixel   = pixel_reg;
    assign advance = !q_empty && (!out_valid_reg || pop);
    assign q_pop   = advance && (pos_reg == yqr_pkg::POS_LAST);

    always_comb
    begin
        y_raw  = q_data.luma[pos_reg];
        y_off  = (y_raw < yqr_pkg::LUMA_OFS) ? '0 : y_raw - yqr_pkg::LUMA_OFS;
        y_ext  = {{(yqr_pkg::SUM_W - yqr_pkg::SAMPLE_W){1'b0}}, y_off};
        y_term = y_ext * yqr_pkg::COEF_Y;
        r_sum  = y_term + {{(yqr_pkg::SUM_W - yqr_pkg::TERM_W){q_data.ruv[yqr_pkg::TERM_W-1]}},
                           q_data.ruv};
        g_sum  = y_term + {{(yqr_pkg::SUM_W - yqr_pkg::TERM_W){q_data.guv[yqr_pkg::TERM_W-1]}},
                           q_data.guv};
        b_sum  = y_term + {{(yqr_pkg::SUM_W - yqr_pkg::TERM_W){q_data.buv[yqr_pkg::TERM_W-1]}},
                           q_data.buv};
        r_val  = clip_shift(r_sum);
        g_val  = clip_shift(g_sum);
        b_val  = clip_shift(b_sum);

        pixel_next.channel0  = cfg.blue_first ? b_val : r_val;
        pixel_next.channel1  = g_val;
        pixel_next.channel2  = cfg.blue_first ? r_val : b_val;
        pixel_next.alpha     = cfg.four_channel ? yqr_pkg::ALPHA_ON : yqr_pkg::ALPHA_OFF;
        pixel_next.pixel_pos = pos_reg;
        pixel_next.last      = (pos_reg == yqr_pkg::POS_LAST);
    end

    always_comb
    begin
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                pos_reg <= pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pixel_reg <= pixel_next;
        end
    end

endmodule

// ----- tb/tb_yuv420_quad_to_rgb_unit.sv -----
// Self-checking testbench for the YUV 4:2:0 quad to RGB converter.
module tb_yuv420_quad_to_rgb_unit;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 100000;
    localparam int RANDOM_PHASES = 8;
    localparam int QUADS_PER_PHASE = 26;
    localparam logic [yqr_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

    // BT.601 gains with 20 fractional bits.
    localparam longint GAIN_Y  = 1220542;
    localparam longint GAIN_UB = 2116026;
    localparam longint GAIN_UG = -409993;
    localparam longint GAIN_VG = -852492;
    localparam longint GAIN_VR = 1673527;
    localparam longint ROUND_BIAS = 524288;

    typedef struct packed {
        logic [yqr_pkg::QUAD_SIZE-1:0][yqr_pkg::SAMPLE_W-1:0] luma;
        logic [yqr_pkg::SAMPLE_W-1:0]                         cfirst;
        logic [yqr_pkg::SAMPLE_W-1:0]                         csecond;
    } quad_in_t;

    class quad_pixel_tracker;
        bit               blue_first   = 1'b1;
        bit               chroma_order = 1'b0;
        bit               four_channel = 1'b0;
        yqr_pkg::pixel_t  expected_pixels[$];
        int unsigned      mismatches   = 0;

        function void write_reg(logic [yqr_pkg::CFG_IDX_W-1:0] idx,
                                logic [yqr_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                yqr_pkg::CFG_BLUE_FIRST:   blue_first   = data[0];
                yqr_pkg::CFG_CHROMA_ORDER: chroma_order = data[0];
                yqr_pkg::CFG_FOUR_CHANNEL: four_channel = data[0];
                default: ;
            endcase
        endfunction

        function logic [yqr_pkg::SAMPLE_W-1:0] clip_to_byte(longint acc);
            if (acc < 0)
                return 8'd0;
            acc = acc >>> yqr_pkg::FRAC_BITS;
            if (acc > 255)
                return yqr_pkg::CHAN_MAX;
            return acc[yqr_pkg::SAMPLE_W-1:0];
        endfunction

        function void note_quad(quad_in_t q);
            longint u, v, r_uv, g_uv, b_uv, y_term;
            logic [yqr_pkg::SAMPLE_W-1:0] red, green, blue;
            yqr_pkg::pixel_t px;
            u = chroma_order ? q.csecond : q.cfirst;
            v = chroma_order ? q.cfirst : q.csecond;
            u = u - 128;
            v = v - 128;
            r_uv = ROUND_BIAS + GAIN_VR * v;
            g_uv = ROUND_BIAS + GAIN_VG * v + GAIN_UG * u;
            b_uv = ROUND_BIAS + GAIN_UB * u;
            for (int k = 0; k < yqr_pkg::QUAD_SIZE; k++)
            begin
                y_term = q.luma[k];
                y_term = (y_term < 16) ? 0 : (y_term - 16) * GAIN_Y;
                red   = clip_to_byte(y_term + r_uv);
                green = clip_to_byte(y_term + g_uv);
                blue  = clip_to_byte(y_term + b_uv);
                px.channel0  = blue_first ? blue : red;
                px.channel1  = green;
                px.channel2  = blue_first ? red : blue;
                px.alpha     = four_channel ? yqr_pkg::ALPHA_ON : yqr_pkg::ALPHA_OFF;
                px.pixel_pos = yqr_pkg::POS_W'(k);
                px.last      = (px.pixel_pos == yqr_pkg::POS_LAST);
                expected_pixels.push_back(px);
            end
        endfunction

        task report(string msg);
            $display("ERROR at %0t: %s", $realtime, msg);
            mismatches++;
        endtask

        task compare_field(string name, int got, int want, int pos);
            if (got != want)
                report($sformatf("pixel %0d field %s: got %0d, expected %0d",
                                 pos, name, got, want));
        endtask

        task check_pixel(yqr_pkg::pixel_t got);
            yqr_pkg::pixel_t want;
            if (expected_pixels.size() == 0)
            begin
                report($sformatf("pixel at position %0d with no quad outstanding",
                                 got.pixel_pos));
                return;
            end
            want = expected_pixels.pop_front();
            compare_field("channel0", got.channel0, want.channel0, want.pixel_pos);
            compare_field("channel1", got.channel1, want.channel1, want.pixel_pos);
            compare_field("channel2", got.channel2, want.channel2, want.pixel_pos);
            compare_field("alpha", got.alpha, want.alpha, want.pixel_pos);
            compare_field("pixel_pos", got.pixel_pos, want.pixel_pos, want.pixel_pos);
            compare_field("last", got.last, want.last, want.pixel_pos);
        endtask
    endclass

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           push = 1'b0;
    logic                           full;
    logic [yqr_pkg::SAMPLE_W-1:0]   luma_top_left = '0;
    logic [yqr_pkg::SAMPLE_W-1:0]   luma_top_right = '0;
    logic [yqr_pkg::SAMPLE_W-1:0]   luma_bottom_left = '0;
    logic [yqr_pkg::SAMPLE_W-1:0]   luma_bottom_right = '0;
    logic [yqr_pkg::SAMPLE_W-1:0]   chroma_first = '0;
    logic [yqr_pkg::SAMPLE_W-1:0]   chroma_second = '0;
    logic                           empty;
    logic                           pop = 1'b0;
    logic [yqr_pkg::SAMPLE_W-1:0]   channel0;
    logic [yqr_pkg::SAMPLE_W-1:0]   channel1;
    logic [yqr_pkg::SAMPLE_W-1:0]   channel2;
    logic [yqr_pkg::SAMPLE_W-1:0]   alpha;
    logic [yqr_pkg::POS_W-1:0]      pixel_pos;
    logic                           last;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [yqr_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [yqr_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    quad_pixel_tracker pixels = new();
    int unsigned       tx_idle = 22;
    int unsigned       rx_idle = 22;
    int unsigned       cycles = 0;
    yqr_pkg::pixel_t   seen_pixel;

    yuv420_quad_to_rgb_unit dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .push             (push),
        .full             (full),
        .luma_top_left    (luma_top_left),
        .luma_top_right   (luma_top_right),
        .luma_bottom_left (luma_bottom_left),
        .luma_bottom_right(luma_bottom_right),
        .chroma_first     (chroma_first),
        .chroma_second    (chroma_second),
        .empty            (empty),
        .pop              (pop),
        .channel0         (channel0),
        .channel1         (channel1),
        .channel2         (channel2),
        .alpha            (alpha),
        .pixel_pos        (pixel_pos),
        .last             (last),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
            pop <= ($urandom_range(99) >= rx_idle);
    end

    // Outputs are sampled in the active region, so they still hold the values
    // that the block presented when the edge arrived.
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            seen_pixel = {channel0, channel1, channel2, alpha, pixel_pos, last};
            pixels.check_pixel(seen_pixel);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic quad_in_t make_quad(int y0, int y1, int y2, int y3, int c1, int c2);
        quad_in_t q;
        q.luma[0] = yqr_pkg::SAMPLE_W'(y0);
        q.luma[1] = yqr_pkg::SAMPLE_W'(y1);
        q.luma[2] = yqr_pkg::SAMPLE_W'(y2);
        q.luma[3] = yqr_pkg::SAMPLE_W'(y3);
        q.cfirst  = yqr_pkg::SAMPLE_W'(c1);
        q.csecond = yqr_pkg::SAMPLE_W'(c2);
        return q;
    endfunction

    // Edge values turn up often so clamping and saturation are hit in random traffic.
    function automatic logic [yqr_pkg::SAMPLE_W-1:0] pick_sample();
        int unsigned corners[12] = '{0, 1, 15, 16, 17, 127, 128, 129, 235, 240, 254, 255};
        if ($urandom_range(3) == 0)
            return yqr_pkg::SAMPLE_W'(corners[$urandom_range(11)]);
        return yqr_pkg::SAMPLE_W'($urandom_range(255));
    endfunction

    function automatic quad_in_t random_quad();
        quad_in_t q;
        for (int k = 0; k < yqr_pkg::QUAD_SIZE; k++)
            q.luma[k] = pick_sample();
        q.cfirst  = pick_sample();
        q.csecond = pick_sample();
        return q;
    endfunction

    task send_quad(quad_in_t q);
        while ($urandom_range(99) < tx_idle)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push              <= 1'b1;
        luma_top_left     <= q.luma[0];
        luma_top_right    <= q.luma[1];
        luma_bottom_left  <= q.luma[2];
        luma_bottom_right <= q.luma[3];
        chroma_first      <= q.cfirst;
        chroma_second     <= q.csecond;
        do
            @(posedge clk);
        while (full);
        pixels.note_quad(q);
    endtask

    task drain_pixels();
        push <= 1'b0;
        while (pixels.expected_pixels.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Leaves cfg_valid high; the caller lowers it after the last transaction.
    task cfg_write(logic [yqr_pkg::CFG_IDX_W-1:0] idx, logic value);
        logic [yqr_pkg::CFG_DATA_W-1:0] data;
        data = {7'($urandom_range(127)), value};
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        pixels.write_reg(idx, data);
    endtask

    // Setting bits are {blue_first, chroma_order, four_channel}.
    task write_config(logic [2:0] setting, bit poke_unused);
        drain_pixels();
        cfg_write(yqr_pkg::CFG_BLUE_FIRST, setting[2]);
        cfg_write(yqr_pkg::CFG_CHROMA_ORDER, setting[1]);
        cfg_write(yqr_pkg::CFG_FOUR_CHANNEL, setting[0]);
        if (poke_unused)
            cfg_write(CFG_UNUSED_IDX, ~setting[2]);
        cfg_valid <= 1'b0;
    endtask

    task run_directed();
        send_quad(make_quad(0, 0, 0, 0, 0, 0));
        send_quad(make_quad(255, 255, 255, 255, 255, 255));
        send_quad(make_quad(15, 16, 17, 0, 128, 128));
        send_quad(make_quad(16, 16, 16, 16, 0, 0));
        send_quad(make_quad(235, 235, 235, 235, 255, 255));
        send_quad(make_quad(16, 235, 128, 255, 0, 255));
        send_quad(make_quad(255, 0, 16, 15, 255, 0));
        send_quad(make_quad(128, 128, 128, 128, 128, 128));
        send_quad(make_quad(81, 145, 41, 210, 90, 240));
        send_quad(make_quad(170, 85, 170, 85, 170, 85));
        send_quad(make_quad(85, 170, 85, 170, 85, 170));
    endtask

    initial
    begin
        logic [2:0] setting;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        write_config(3'b011, 1'b0);
        run_directed();

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0: setting = 3'b000;
                1: setting = 3'b111;
                2: setting = 3'b010;
                3: setting = 3'b101;
                default: setting = 3'($urandom_range(7));
            endcase
            write_config(setting, phase == 5);
            tx_idle = (phase == 3) ? 0 : 22;
            rx_idle = (phase == 3) ? 0 : 22;
            for (int n = 0; n < QUADS_PER_PHASE; n++)
            begin
                // Let the block run completely dry once in the middle of traffic.
                if (phase == 2 && n == QUADS_PER_PHASE / 2)
                    drain_pixels();
                send_quad(random_quad());
            end
        end

        drain_pixels();
        repeat (8) @(posedge clk);
        if (pixels.mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
